// ===== rtl/irp_pkg.sv =====
// Shared types and constants for the idle residency profiler.
package irp_pkg;

	localparam int unsigned DEF_NUM_CPUS       = 8;
	localparam int unsigned DEF_NUM_CPU_STATES = 4;
	localparam int unsigned DEF_NUM_CLUSTERS   = 2;
	localparam int unsigned DEF_NUM_LPM_MODES  = 4;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 4;

	typedef enum logic [1:0] {
		ACT_ENTER = 2'd0,
		ACT_EXIT  = 2'd1,
		ACT_READ  = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		KIND_CPU     = 2'd0,
		KIND_CLUSTER = 2'd1,
		KIND_LPM     = 2'd2
	} kind_t;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_OFF   = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_C2_STATE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LPM_STATE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CPD_SUB   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SICD_SUB  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LPM_SICD  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CLU_SHIFT = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SUB_MASK  = 3'd7;

endpackage

// ===== rtl/irp_if.sv =====
// Event and result channel interfaces of the idle residency profiler.
interface irp_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [2:0]  cpu;
	logic [1:0]  idle_state;
	logic [2:0]  sub_state;
	logic        early_wakeup;
	logic [63:0] timestamp;
	logic [1:0]  record_kind;

	modport source (output valid, action, cpu, idle_state, sub_state, early_wakeup,
		timestamp, record_kind, input ready);
	modport sink (input valid, action, cpu, idle_state, sub_state, early_wakeup,
		timestamp, record_kind, output ready);
endinterface

interface irp_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] entry_total;
	logic [31:0] early_count;
	logic [63:0] residency_ns;
	logic        in_state;
	logic [1:0]  current_state;

	modport source (output valid, status, entry_total, early_count, residency_ns,
		in_state, current_state, input ready);
	modport sink (input valid, status, entry_total, early_count, residency_ns,
		in_state, current_state, output ready);
endinterface

// ===== rtl/idle_residency_profiler.sv =====
// Idle residency profiler top level: record flops, counter memory and sequencer.
//
//  channel | dir | handshake     | payload
//  req     | in  | valid/ready   | action, cpu, idle_state, sub_state, early_wakeup,
//          |     |               | timestamp, record_kind
//  rsp     | out | valid/ready   | status, entry_total, early_count, residency_ns,
//          |     |               | in_state, current_state
//  cfg     | in  | cfg_we        | cfg_idx, cfg_wdata
//
// One transaction at a time: after accept, each counter touched takes a read state and a
// write-back state, each unused slot only a read state, then a result state and a
// return to idle before the next accept.
// Counters sit in one memory with a registered read; the three slots go serially.
// Reset and clear drop every counter valid bit at once; no sweep.
// req.ready stays low until the result has been taken.
module idle_residency_profiler
	import irp_pkg::*;
#(
	parameter int unsigned NUM_CPUS       = DEF_NUM_CPUS,
	parameter int unsigned NUM_CPU_STATES = DEF_NUM_CPU_STATES,
	parameter int unsigned NUM_CLUSTERS   = DEF_NUM_CLUSTERS,
	parameter int unsigned NUM_LPM_MODES  = DEF_NUM_LPM_MODES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	irp_req_if.sink               req,
	irp_rsp_if.source             rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int unsigned CPU_BASE = 0;
	localparam int unsigned CLU_BASE = NUM_CPUS * NUM_CPU_STATES;
	localparam int unsigned LPM_BASE = CLU_BASE + NUM_CLUSTERS;
	localparam int unsigned DEPTH    = LPM_BASE + NUM_LPM_MODES;
	localparam int unsigned AW       = $clog2(DEPTH);
	localparam int unsigned CIW      = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int unsigned LIW      = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;

	typedef enum logic [1:0] {OP_ENT, OP_EARLY, OP_RES, OP_READ} op_t;
	typedef enum logic [1:0] {S_IDLE, S_RD, S_WR, S_OUT} state_t;

	typedef struct packed {
		logic          vld;
		logic [AW-1:0] addr;
		op_t           op;
		logic [63:0]   delta;
	} slot_t;

	// configuration
	logic       enable_q;
	logic [1:0] c2_q, lpmst_q, sicd_idx_q, shift_q;
	logic [2:0] cpd_q, sicd_q;
	logic [3:0] mask_q;

	// records
	logic        cpu_act_q [NUM_CPUS];
	logic [1:0]  cpu_cur_q [NUM_CPUS];
	logic [63:0] cpu_stamp_q [NUM_CPUS];
	logic        clu_act_q [NUM_CLUSTERS];
	logic [63:0] clu_stamp_q [NUM_CLUSTERS];
	logic        lpm_act_q;
	logic [1:0]  lpm_cur_q;
	logic [63:0] lpm_stamp_q;

	// counter memory: {entries, earlies, residency}
	logic [127:0] mem [DEPTH];
	logic         vld_q [DEPTH];
	logic [127:0] rd_s1;
	logic         rd_vld_s1;

	state_t      state_q;
	logic [1:0]  idx_q;
	slot_t       slot_q [3];
	logic [1:0]  status_q;
	logic        in_state_q;
	logic [1:0]  cur_state_q;
	logic [31:0] ent_q, early_q;
	logic [63:0] res_q;

	// accept-time decode
	logic          acc;
	logic [2:0]    clu;
	logic [CIW-1:0] ci;
	logic [LIW-1:0] li;
	logic          cpu_ok, st_ok, clu_ok;
	logic [1:0]    a_status;
	slot_t         a_slot [3];
	logic          cpu_open, clu_open, lpm_open, cpu_close, clu_close, lpm_close, a_clr;
	logic          is_c2, is_cpd, is_sicd, is_lpm;
	logic [2:0]    slot;
	logic          was_in, subs;
	logic [1:0]    prev;
	logic          a_in_state;
	logic [1:0]    a_cur;

	assign acc    = req.valid && req.ready;
	assign clu    = req.cpu >> shift_q;
	assign ci     = req.cpu[CIW-1:0];
	assign li     = clu[LIW-1:0];
	assign cpu_ok = 32'(req.cpu) < NUM_CPUS;
	assign st_ok  = 32'(req.idle_state) < NUM_CPU_STATES;
	assign clu_ok = 32'(clu) < NUM_CLUSTERS;

	always_comb begin
		a_status   = ST_DONE;
		for (int i = 0; i < 3; i++) a_slot[i] = '0;
		cpu_open   = 1'b0;
		clu_open   = 1'b0;
		lpm_open   = 1'b0;
		cpu_close  = 1'b0;
		clu_close  = 1'b0;
		lpm_close  = 1'b0;
		a_clr      = 1'b0;
		a_in_state = 1'b0;
		a_cur      = '0;
		is_c2      = (req.sub_state != 3'd0) && (req.idle_state == c2_q);
		is_cpd     = is_c2 && (req.sub_state == cpd_q);
		is_sicd    = is_c2 && !is_cpd && (req.sub_state == sicd_q);
		is_lpm     = (req.sub_state != 3'd0) && !is_c2 && (req.idle_state == lpmst_q);
		slot       = is_sicd ? {1'b0, sicd_idx_q} : req.sub_state;
		was_in     = cpu_act_q[ci];
		prev       = cpu_cur_q[ci];
		subs       = was_in && (32'(prev) < NUM_CPU_STATES) && mask_q[prev];
		unique case (action_t'(req.action))
			ACT_ENTER: begin
				if (!enable_q) begin
					a_status = ST_OFF;
				end else if (!cpu_ok || !st_ok || (is_cpd && !clu_ok) ||
						((is_sicd || is_lpm) && 32'(slot) >= NUM_LPM_MODES)) begin
					a_status = ST_RANGE;
				end else begin
					cpu_open  = !was_in;
					clu_open  = is_cpd && !clu_act_q[li];
					lpm_open  = (is_sicd || is_lpm) && !lpm_act_q;
					a_slot[0] = '{cpu_open,
						AW'(CPU_BASE + 32'(req.cpu) * NUM_CPU_STATES + 32'(req.idle_state)),
						OP_ENT, 64'd0};
					a_slot[1] = '{clu_open || lpm_open,
						clu_open ? AW'(CLU_BASE + 32'(clu)) : AW'(LPM_BASE + 32'(slot)),
						OP_ENT, 64'd0};
				end
			end
			ACT_EXIT: begin
				if (!enable_q) begin
					a_status = ST_OFF;
				end else if (!cpu_ok || (subs && !clu_ok)) begin
					a_status = ST_RANGE;
				end else begin
					cpu_close = was_in && (32'(prev) < NUM_CPU_STATES);
					clu_close = subs && clu_act_q[li];
					lpm_close = subs && lpm_act_q;
					a_slot[0] = '{cpu_close,
						AW'(CPU_BASE + 32'(req.cpu) * NUM_CPU_STATES + 32'(prev)),
						req.early_wakeup ? OP_EARLY : OP_RES,
						req.timestamp - cpu_stamp_q[ci]};
					a_slot[1] = '{clu_close, AW'(CLU_BASE + 32'(clu)),
						req.early_wakeup ? OP_EARLY : OP_RES,
						req.timestamp - clu_stamp_q[li]};
					a_slot[2] = '{lpm_close, AW'(LPM_BASE + 32'(lpm_cur_q)),
						req.early_wakeup ? OP_EARLY : OP_RES,
						req.timestamp - lpm_stamp_q};
				end
			end
			ACT_CLEAR: a_clr = 1'b1;
			ACT_READ: begin
				a_status = ST_RANGE;
				unique case (req.record_kind)
					KIND_CPU: if (cpu_ok && st_ok) begin
						a_status   = ST_DONE;
						a_slot[0]  = '{1'b1,
							AW'(CPU_BASE + 32'(req.cpu) * NUM_CPU_STATES +
							32'(req.idle_state)), OP_READ, 64'd0};
						a_in_state = was_in;
						a_cur      = was_in ? prev : 2'd0;
					end
					KIND_CLUSTER: if (32'(req.cpu) < NUM_CLUSTERS &&
							req.idle_state == 2'd0) begin
						a_status   = ST_DONE;
						a_slot[0]  = '{1'b1, AW'(CLU_BASE + 32'(req.cpu)), OP_READ, 64'd0};
						a_in_state = clu_act_q[req.cpu[LIW-1:0]];
					end
					KIND_LPM: if (32'(req.idle_state) < NUM_LPM_MODES) begin
						a_status   = ST_DONE;
						a_slot[0]  = '{1'b1, AW'(LPM_BASE + 32'(req.idle_state)),
							OP_READ, 64'd0};
						a_in_state = lpm_act_q;
						a_cur      = lpm_act_q ? lpm_cur_q : 2'd0;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			c2_q       <= 2'd1;
			lpmst_q    <= 2'd2;
			cpd_q      <= 3'd1;
			sicd_q     <= 3'd2;
			sicd_idx_q <= 2'd0;
			shift_q    <= 2'd2;
			mask_q     <= 4'd2;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ENABLE:    enable_q   <= cfg_wdata[0];
				REG_C2_STATE:  c2_q       <= cfg_wdata[1:0];
				REG_LPM_STATE: lpmst_q    <= cfg_wdata[1:0];
				REG_CPD_SUB:   cpd_q      <= cfg_wdata[2:0];
				REG_SICD_SUB:  sicd_q     <= cfg_wdata[2:0];
				REG_LPM_SICD:  sicd_idx_q <= cfg_wdata[1:0];
				REG_CLU_SHIFT: shift_q    <= cfg_wdata[1:0];
				REG_SUB_MASK:  mask_q     <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	// record flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CPUS; i++) cpu_act_q[i] <= 1'b0;
			for (int i = 0; i < NUM_CLUSTERS; i++) clu_act_q[i] <= 1'b0;
			lpm_act_q <= 1'b0;
		end else if (acc) begin
			if (a_clr) begin
				for (int i = 0; i < NUM_CPUS; i++) cpu_act_q[i] <= 1'b0;
				for (int i = 0; i < NUM_CLUSTERS; i++) clu_act_q[i] <= 1'b0;
				lpm_act_q <= 1'b0;
			end else begin
				if (cpu_open) cpu_act_q[ci] <= 1'b1;
				if (cpu_close) cpu_act_q[ci] <= 1'b0;
				if (clu_open) clu_act_q[li] <= 1'b1;
				if (clu_close) clu_act_q[li] <= 1'b0;
				if (lpm_open) lpm_act_q <= 1'b1;
				if (lpm_close) lpm_act_q <= 1'b0;
			end
		end
	end

	// record payload; stamps are only read while the record is active
	always_ff @(posedge clk) begin
		if (acc) begin
			if (cpu_open) begin
				cpu_cur_q[ci]   <= req.idle_state;
				cpu_stamp_q[ci] <= req.timestamp;
			end
			if (clu_open) clu_stamp_q[li] <= req.timestamp;
			if (lpm_open) begin
				lpm_cur_q   <= slot[1:0];
				lpm_stamp_q <= req.timestamp;
			end
		end
	end

	// read-modify-write datapath
	slot_t        cur;
	logic [127:0] base, wdata;

	assign cur  = slot_q[idx_q];
	assign base = rd_vld_s1 ? rd_s1 : 128'd0;

	always_comb begin
		wdata = base;
		unique case (cur.op)
			OP_ENT:   wdata[127:96] = base[127:96] + 32'd1;
			OP_EARLY: wdata[95:64]  = base[95:64] + 32'd1;
			OP_RES:   wdata[63:0]   = base[63:0] + cur.delta;
			OP_READ:  ;
			default:  ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RD && cur.vld) begin
			rd_s1 <= mem[cur.addr];
		end
		if (state_q == S_WR && cur.op != OP_READ) begin
			mem[cur.addr] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) vld_q[i] <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (acc && a_clr) begin
				for (int i = 0; i < DEPTH; i++) vld_q[i] <= 1'b0;
			end
			if (state_q == S_RD && cur.vld) rd_vld_s1 <= vld_q[cur.addr];
			if (state_q == S_WR && cur.op != OP_READ) vld_q[cur.addr] <= 1'b1;
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= 2'd0;
		end else begin
			unique case (state_q)
				S_IDLE: if (acc) begin
					state_q <= S_RD;
					idx_q   <= 2'd0;
				end
				S_RD: begin
					if (cur.vld) state_q <= S_WR;
					else if (idx_q == 2'd2) state_q <= S_OUT;
					else idx_q <= idx_q + 2'd1;
				end
				S_WR: begin
					if (idx_q == 2'd2) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_RD;
						idx_q   <= idx_q + 2'd1;
					end
				end
				S_OUT: if (rsp.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			for (int i = 0; i < 3; i++) slot_q[i] <= a_slot[i];
			status_q    <= a_status;
			in_state_q  <= a_in_state;
			cur_state_q <= a_cur;
			ent_q       <= '0;
			early_q     <= '0;
			res_q       <= '0;
		end else if (state_q == S_WR && cur.op == OP_READ) begin
			ent_q   <= base[127:96];
			early_q <= base[95:64];
			res_q   <= base[63:0];
		end
	end

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = (state_q == S_OUT);
	assign rsp.status        = status_q;
	assign rsp.entry_total   = ent_q;
	assign rsp.early_count   = early_q;
	assign rsp.residency_ns  = res_q;
	assign rsp.in_state      = in_state_q;
	assign rsp.current_state = cur_state_q;

endmodule

// ===== rtl/irp_checker.sv =====
// Port-level checks for the idle residency profiler, bound to the top level.
module irp_checker
	import irp_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [1:0] rsp_status
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
		else $error("result dropped or changed while stalled");

	// one transaction in flight: no new event while a result waits
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("event accepted while result pending");

	// a result never shows in the cycle after acceptance
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !rsp_valid && !req_ready)
		else $error("result too early or ready too soon");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == ST_DONE || rsp_status == ST_OFF ||
		rsp_status == ST_RANGE))
		else $error("undefined status code");

endmodule

bind idle_residency_profiler irp_checker u_irp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status)
);
